// File: rtl/imcf_pkg.sv
`timescale 1ns / 1ps

package imcf_pkg;

  localparam int DATA_W    = 10;
  localparam int POS_W     = 16;
  localparam int OFF_W     = 8;
  localparam int SPR_W     = 15;
  localparam int PHASE_W   = 3;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = 16;

  localparam logic [PHASE_W-1:0] PH_WAIT_LOW  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SEEK_RISE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SEEK_FALL = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DONE      = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ABORT     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_OFF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPR      = 2'd3;

  localparam int RST_LOW  = 240;
  localparam int RST_HIGH = 350;
  localparam int RST_OFF  = 10;
  localparam int RST_SPR  = 2048;

  typedef struct packed {
    logic [PHASE_W-1:0]      phase;
    logic signed [POS_W-1:0] midpoint;
    logic                    found;
  } rec_t;

  typedef struct packed {
    logic signed [POS_W-1:0] start;
    logic signed [POS_W-1:0] stop;
    logic                    wrap;
    logic [SPR_W-1:0]        spr;
  } mid_req_t;

endpackage

// File: rtl/imcf_if.sv
`timescale 1ns / 1ps

interface imcf_item_if import imcf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [DATA_W-1:0]       sensor_sample;
  logic signed [POS_W-1:0] position;

  modport source (output valid, func, sensor_sample, position, input ready);
  modport sink (input valid, func, sensor_sample, position, output ready);
endinterface

interface imcf_result_if import imcf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PHASE_W-1:0]      phase;
  logic [DATA_W-1:0]       average;
  logic signed [POS_W-1:0] midpoint;
  logic                    found;

  modport source (output valid, phase, average, midpoint, found, input ready);
  modport sink (input valid, phase, average, midpoint, found, output ready);
endinterface

// File: rtl/index_mark_center_finder.sv
`timescale 1ns / 1ps

// Index mark centre finder. Takes one sample transaction per clock unless the
// result path stalls or a midpoint is in work: the ten-sample (WINDOW_LEN)
// running sum lives in a small RAM that is read one entry ahead of the write
// pointer, so each sample costs one add-subtract and one threshold compare. A
// restart clears the window at once through per-entry valid bits; there is no
// clearing pass. The transaction that completes the search hands the midpoint
// to a separate unit that, when the mark straddles the revolution boundary,
// reduces the midpoint modulo the revolution (one remainder bit per cycle);
// input is held until the unit is idle. Results pass through two register
// stages, the second of which divides the sum by WINDOW_LEN.
module index_mark_center_finder import imcf_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  imcf_item_if.sink            item,
  imcf_result_if.source        result
);

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = DATA_W + PTR_W;
  localparam int LIM_W = SUM_W + 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(WINDOW_LEN - 1);

  logic [DATA_W-1:0]       low_thr;
  logic [LIM_W-1:0]        rise_lim;
  logic [LIM_W-1:0]        fall_lim;
  logic [OFF_W-1:0]        pos_off;
  logic [SPR_W-1:0]        spr;
  logic [PHASE_W-1:0]      phase;
  logic [PTR_W-1:0]        ptr;
  logic [SUM_W-1:0]        sum;
  logic [WINDOW_LEN-1:0]   win_valid;
  logic signed [POS_W-1:0] mark_start;
  logic signed [POS_W-1:0] mark_mid;

  logic                    s1_valid;
  rec_t                    s1_rec;
  logic [SUM_W-1:0]        s1_sum;
  logic                    s1_ready;

  logic [PHASE_W-1:0]      phase_next;
  logic [PTR_W-1:0]        ptr_next;
  logic [SUM_W-1:0]        sum_next;
  logic signed [POS_W-1:0] start_next;

  logic                    acc;
  logic                    push;
  logic                    clear;
  logic                    mid_go;
  logic [DATA_W-1:0]       ram_rdata;
  logic [DATA_W-1:0]       old;
  logic [SUM_W-1:0]        sum_push;
  logic signed [POS_W-1:0] mark_pos;
  logic [PTR_W-1:0]        ptr_inc;
  logic [PTR_W-1:0]        raddr;

  mid_req_t                mid_req;
  logic                    mid_idle;
  logic                    mid_res_valid;
  logic signed [POS_W-1:0] mid_res;
  logic                    mid_take;
  logic                    avg_ready;

  assign acc      = item.valid && item.ready;
  assign old      = win_valid[ptr] ? ram_rdata : '0;
  assign sum_push = sum - SUM_W'(old) + SUM_W'(item.sensor_sample);
  assign mark_pos = item.position - POS_W'(pos_off);
  assign ptr_inc  = (ptr == LAST) ? '0 : ptr + 1'b1;
  assign raddr    = rst ? '0 : ptr_next;
  assign s1_ready = !s1_valid || avg_ready;
  assign mid_take = mid_res_valid && s1_ready;

  assign item.ready = s1_ready && mid_idle;

  always_comb begin
    push       = 1'b0;
    clear      = 1'b0;
    mid_go     = 1'b0;
    phase_next = phase;
    start_next = mark_start;
    if (acc) begin
      if (item.func) begin
        clear      = 1'b1;
        phase_next = PH_WAIT_LOW;
        start_next = '0;
      end else begin
        unique case (phase)
          PH_WAIT_LOW: begin
            push = 1'b1;
            if (item.sensor_sample < low_thr) phase_next = PH_SEEK_RISE;
          end
          PH_SEEK_RISE: begin
            if (item.sensor_sample == '0) begin
              phase_next = PH_ABORT;
            end else begin
              push = 1'b1;
              if ({1'b0, sum_push} >= rise_lim) begin
                start_next = mark_pos;
                phase_next = PH_SEEK_FALL;
              end
            end
          end
          PH_SEEK_FALL: begin
            push = 1'b1;
            if ({1'b0, sum_push} < fall_lim) begin
              mid_go     = 1'b1;
              phase_next = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
    if (clear) begin
      sum_next = '0;
      ptr_next = '0;
    end else if (push) begin
      sum_next = sum_push;
      ptr_next = ptr_inc;
    end else begin
      sum_next = sum;
      ptr_next = ptr;
    end
  end

  always_comb begin
    mid_req.start = mark_start;
    mid_req.stop  = mark_pos;
    mid_req.wrap  = mark_pos < mark_start;
    mid_req.spr   = spr;
  end

  imcf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (push),
    .waddr (ptr),
    .wdata (item.sensor_sample),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  imcf_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .go        (mid_go),
    .req       (mid_req),
    .idle      (mid_idle),
    .res_valid (mid_res_valid),
    .res_ready (s1_ready),
    .res       (mid_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr    <= DATA_W'(RST_LOW);
      rise_lim   <= LIM_W'((RST_HIGH + 1) * WINDOW_LEN);
      fall_lim   <= LIM_W'(RST_HIGH * WINDOW_LEN);
      pos_off    <= OFF_W'(RST_OFF);
      spr        <= SPR_W'(RST_SPR);
      phase      <= PH_WAIT_LOW;
      ptr        <= '0;
      sum        <= '0;
      win_valid  <= '0;
      mark_start <= '0;
      mark_mid   <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOW_THR:  low_thr <= cfg_data[DATA_W-1:0];
          REG_HIGH_THR: begin
            rise_lim <= (LIM_W'(cfg_data[DATA_W-1:0]) + 1'b1) * LIM_W'(WINDOW_LEN);
            fall_lim <= LIM_W'(cfg_data[DATA_W-1:0]) * LIM_W'(WINDOW_LEN);
          end
          REG_POS_OFF:  pos_off <= cfg_data[OFF_W-1:0];
          REG_SPR:      spr <= cfg_data[SPR_W-1:0];
          default: ;
        endcase
      end
      phase      <= phase_next;
      ptr        <= ptr_next;
      sum        <= sum_next;
      mark_start <= start_next;
      if (clear) begin
        win_valid <= '0;
      end else if (push) begin
        win_valid[ptr] <= 1'b1;
      end
      if (clear) begin
        mark_mid <= '0;
      end else if (mid_take) begin
        mark_mid <= mid_res;
      end
      if (s1_ready) begin
        s1_valid <= (acc && !mid_go) || mid_take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      if (mid_take) begin
        s1_rec.phase    <= PH_DONE;
        s1_rec.midpoint <= mid_res;
        s1_rec.found    <= 1'b1;
        s1_sum          <= sum;
      end else begin
        s1_rec.phase    <= phase_next;
        s1_rec.midpoint <= clear ? '0 : mark_mid;
        s1_rec.found    <= 1'b0;
        s1_sum          <= sum_next;
      end
    end
  end

  imcf_avg #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_avg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_ready (avg_ready),
    .rec      (s1_rec),
    .sum      (s1_sum),
    .result   (result)
  );

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    acc && item.func |=> phase == PH_WAIT_LOW && sum == '0 && win_valid == '0)
    else $error("restart did not clear the window");

  a_final_phase_holds: assert property (@(posedge clk) disable iff (rst)
    acc && !item.func && (phase == PH_DONE || phase == PH_ABORT)
    |=> $stable(phase) && $stable(sum) && $stable(ptr))
    else $error("window or phase moved after the search ended");

  a_found_holds_input: assert property (@(posedge clk) disable iff (rst)
    acc && mid_go |=> !mid_idle && !item.ready && phase == PH_DONE)
    else $error("input not held while the midpoint is computed");

  a_mid_result_loaded: assert property (@(posedge clk) disable iff (rst)
    mid_take |=> s1_valid && s1_rec.found && s1_rec.phase == PH_DONE)
    else $error("midpoint result lost");

endmodule

// File: rtl/imcf_ram.sv
`timescale 1ns / 1ps

module imcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/imcf_mid.sv
`timescale 1ns / 1ps

module imcf_mid import imcf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  mid_req_t                req,
  output logic                    idle,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic signed [POS_W-1:0] res
);

  localparam int T_W   = POS_W + 2;
  localparam int CNT_W = $clog2(MAG_W);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_SUM  = 3'd1;
  localparam logic [2:0] M_HALF = 3'd2;
  localparam logic [2:0] M_REM  = 3'd3;
  localparam logic [2:0] M_SIGN = 3'd4;
  localparam logic [2:0] M_DONE = 3'd5;

  logic [2:0]       state;
  mid_req_t         hold;
  logic [T_W-1:0]   t;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] rem;
  logic [CNT_W-1:0] cnt;

  logic [T_W-1:0]   tmag;
  logic [MAG_W:0]   rs;
  logic [MAG_W:0]   rs_sub;

  assign tmag   = t[T_W-1] ? T_W'(-t) : t;
  assign rs     = {rem, mag[MAG_W-1]};
  assign rs_sub = (rs >= (MAG_W+1)'(hold.spr)) ? rs - (MAG_W+1)'(hold.spr) : rs;

  assign idle      = (state == M_IDLE);
  assign res_valid = (state == M_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      unique case (state)
        M_IDLE: if (go) state <= M_SUM;
        M_SUM:  state <= M_HALF;
        M_HALF: state <= (hold.wrap && hold.spr != '0) ? M_REM : M_SIGN;
        M_REM:  if (cnt == '0) state <= M_SIGN;
        M_SIGN: state <= M_DONE;
        M_DONE: if (res_ready) state <= M_IDLE;
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      M_IDLE: begin
        if (go) hold <= req;
      end
      M_SUM: begin
        t <= T_W'(hold.start) + T_W'(hold.stop) + (hold.wrap ? T_W'(hold.spr) : '0);
      end
      M_HALF: begin
        neg <= t[T_W-1];
        mag <= tmag[MAG_W:1];
        rem <= (hold.wrap && hold.spr != '0) ? '0 : tmag[MAG_W:1];
        cnt <= CNT_W'(MAG_W - 1);
      end
      M_REM: begin
        rem <= rs_sub[MAG_W-1:0];
        mag <= {mag[MAG_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      M_SIGN: begin
        res <= neg ? POS_W'(-{1'b0, rem}) : POS_W'({1'b0, rem});
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/imcf_avg.sv
`timescale 1ns / 1ps

module imcf_avg import imcf_pkg::*; #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rec_t                                  rec,
  input  logic [DATA_W+$clog2(WINDOW_LEN)-1:0]  sum,
  imcf_result_if.source                         result
);

  localparam int LW      = $clog2(WINDOW_LEN);
  localparam int SUM_W   = DATA_W + LW;
  localparam int SHIFT   = SUM_W + LW;
  localparam int PROD_W  = 2 * SUM_W + 2;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;

  logic [PROD_W-1:0] prod;
  logic              valid;

  assign prod     = PROD_W'(sum) * PROD_W'(RECIP);
  assign in_ready = !valid || result.ready;

  assign result.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result.phase    <= rec.phase;
      result.midpoint <= rec.midpoint;
      result.found    <= rec.found;
      result.average  <= prod[SHIFT +: DATA_W];
    end
  end

endmodule
